// ===== hdl/mwtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-window text console package
// Transaction types, access codes, datapath operations and fixed constants.
// ----------------------------------------------------------------------------
package mwtc_pkg;

  typedef enum logic [1:0] {
    ACT_PORT_READ  = 2'd0,
    ACT_PORT_WRITE = 2'd1,
    ACT_KEY_TYPED  = 2'd2,
    ACT_CELL_READ  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PORT_SELECT  = 2'd0,
    PORT_UPLOAD  = 2'd1,
    PORT_KEY     = 2'd2,
    PORT_INVALID = 2'd3
  } port_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_DECODE,
    OP_PREP,
    OP_DOWN,
    OP_PUT,
    OP_NL,
    OP_CR,
    OP_BLANK,
    OP_SCROLL,
    OP_COMMIT,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  port;
    logic [15:0] write_data;
    logic [8:0]  key_code;
    logic [1:0]  cell_window;
    logic [4:0]  cell_row;
    logic [5:0]  cell_col;
  } in_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [7:0]  cell_char;
    logic        key_pending;
    logic        bad_access;
  } out_t;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic upload;
    logic wrap;
    logic last_row;
    logic ch_nl;
    logic ch_cr;
    logic blank_done;
    logic scroll_done;
    logic out_free;
  } sts_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 7;
  localparam int RowsRegW = 6;
  localparam int ColsRegW = 7;
  localparam int CfgWin   = 4;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [8:0] KEY_DEL  = 9'd127;
  localparam logic [8:0] KEY_BS   = 9'd8;

  localparam logic [RowsRegW-1:0] ROWS_RESET [CfgWin] = '{6'd22, 6'd10, 6'd10, 6'd22};
  localparam logic [ColsRegW-1:0] COLS_RESET [CfgWin] = '{7'd24, 7'd24, 7'd24, 7'd24};

endpackage

// ===== hdl/mwtc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-window text console controller
// Sequences clearing, decoding, printing, blanking and scrolling steps.
// ----------------------------------------------------------------------------
module mwtc_ctrl
  import mwtc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_PREP, ST_WRAP, ST_CHAR, ST_BLANK,
    ST_NLDOWN, ST_SCROLL, ST_COMMIT, ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    RET_CHAR, RET_NLDOWN, RET_DONE
  } ret_e;

  state_e state_q, state_d;
  ret_e   ret_q, ret_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.op = OP_DECODE;
        state_d  = sts_i.upload ? ST_PREP : ST_FINISH;
      end
      ST_PREP: begin
        cmd_o.op = OP_PREP;
        state_d  = ST_WRAP;
      end
      ST_WRAP: begin
        if (sts_i.wrap) begin
          cmd_o.op = OP_DOWN;
          if (sts_i.last_row) begin
            ret_d   = RET_CHAR;
            state_d = ST_SCROLL;
          end else begin
            state_d = ST_CHAR;
          end
        end else begin
          state_d = ST_CHAR;
        end
      end
      ST_CHAR: begin
        priority if (sts_i.ch_nl) begin
          cmd_o.op = OP_NL;
          ret_d    = RET_NLDOWN;
          state_d  = ST_BLANK;
        end else if (sts_i.ch_cr) begin
          cmd_o.op = OP_CR;
          ret_d    = RET_DONE;
          state_d  = ST_BLANK;
        end else begin
          cmd_o.op = OP_PUT;
          state_d  = ST_COMMIT;
        end
      end
      ST_BLANK: begin
        cmd_o.op = OP_BLANK;
        if (sts_i.blank_done) begin
          unique case (ret_q)
            RET_CHAR:   state_d = ST_CHAR;
            RET_NLDOWN: state_d = ST_NLDOWN;
            default:    state_d = ST_COMMIT;
          endcase
        end
      end
      ST_NLDOWN: begin
        cmd_o.op = OP_DOWN;
        if (sts_i.last_row) begin
          ret_d   = RET_DONE;
          state_d = ST_SCROLL;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_SCROLL: begin
        cmd_o.op = OP_SCROLL;
        if (sts_i.scroll_done) state_d = ST_BLANK;
      end
      ST_COMMIT: begin
        cmd_o.op = OP_COMMIT;
        state_d  = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      ret_q   <= RET_DONE;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  property p_no_accept_while_busy;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q != ST_IDLE) |-> in_stall_o;
  endproperty
  a_no_accept_while_busy: assert property (p_no_accept_while_busy)
    else $error("Input accepted while an item is in progress.");

  property p_load_leads_to_decode;
    @(posedge clk_i) disable iff (!rst_ni)
      (cmd_o.op == OP_LOAD) |=> (state_q == ST_DECODE);
  endproperty
  a_load_leads_to_decode: assert property (p_load_leads_to_decode)
    else $error("Loaded transaction was not decoded.");

endmodule

// ===== hdl/mwtc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-window text console datapath
// Character memory, cursors, window sizes, keyboard latch and result register.
// ----------------------------------------------------------------------------
module mwtc_datapath
  import mwtc_pkg::*;
#(
  parameter int MAX_ROWS      = 32,
  parameter int MAX_COLS      = 64,
  parameter int WINDOW_COUNT  = 4,
  parameter int BACKSPACE_KEY = 263
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  in_t                 in_data_i,
  output out_t                out_data_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o
);

  localparam int WB    = (WINDOW_COUNT > 1) ? $clog2(WINDOW_COUNT) : 1;
  localparam int RB    = $clog2(MAX_ROWS);
  localparam int CB    = $clog2(MAX_COLS);
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int AW    = WB + RB + CB;
  localparam int DEPTH = 1 << AW;

  function automatic logic [AW-1:0] cell_addr(logic [WB-1:0] w, logic [RB-1:0] r,
                                              logic [CB-1:0] c);
    return {w, r, c};
  endfunction

  logic [7:0] mem [DEPTH];

  logic [RowsRegW-1:0] rows_q [CfgWin];
  logic [ColsRegW-1:0] cols_q [CfgWin];
  logic [CCW-1:0]      cur_x_q [WINDOW_COUNT];
  logic [RB-1:0]       cur_y_q [WINDOW_COUNT];
  logic [WB-1:0]       sel_q;
  logic [8:0]          key_q;
  logic                key_wait_q;
  logic [AW-1:0]       clr_q;
  logic                pend_q;
  logic [AW-1:0]       pend_addr_q;
  logic                out_valid_q;

  in_t            in_q;
  out_t           out_q;
  logic [CCW-1:0] x_q, bc_q;
  logic [RB-1:0]  y_q;
  logic [RCW-1:0] sr_q;
  logic [CB-1:0]  sc_q;
  logic [7:0]     rd_q;
  logic [15:0]    rdata_q;
  logic           bad_q, cell_ok_q;

  logic [RowsRegW-1:0] rows_raw;
  logic [ColsRegW-1:0] cols_raw;
  logic [RCW-1:0]      rows_eff;
  logic [CCW-1:0]      cols_eff;
  logic                cell_ok, pend_d, we, ren;
  logic [AW-1:0]       waddr, raddr;
  logic [7:0]          wdat;
  logic [7:0]          ch;

  assign rows_raw = rows_q[2'(sel_q)];
  assign cols_raw = cols_q[2'(sel_q)];
  assign rows_eff = (rows_raw == '0) ? RCW'(1) :
                    (int'(rows_raw) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(rows_raw);
  assign cols_eff = (cols_raw == '0) ? CCW'(1) :
                    (int'(cols_raw) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(cols_raw);
  assign ch       = in_q.write_data[7:0];
  assign cell_ok  = (int'(in_q.cell_window) < WINDOW_COUNT) &&
                    (int'(in_q.cell_row) < MAX_ROWS) && (int'(in_q.cell_col) < MAX_COLS);

  assign sts_o.clr_done    = &clr_q;
  assign sts_o.upload      = (in_q.action == ACT_PORT_WRITE) && (in_q.port == PORT_UPLOAD);
  assign sts_o.wrap        = (x_q >= cols_eff);
  assign sts_o.last_row    = ((RCW'(y_q) + RCW'(1)) >= rows_eff);
  assign sts_o.ch_nl       = (ch == CH_NL);
  assign sts_o.ch_cr       = (ch == CH_CR);
  assign sts_o.blank_done  = (bc_q >= cols_eff);
  assign sts_o.scroll_done = (sr_q >= rows_eff);
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

  assign pend_d      = (cmd_i.op == OP_SCROLL) && !sts_o.scroll_done;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    we    = 1'b0;
    waddr = pend_addr_q;
    wdat  = rd_q;
    priority if (cmd_i.op == OP_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdat  = CH_SPACE;
    end else if (pend_q) begin
      we = 1'b1;
    end else if (cmd_i.op == OP_BLANK && !sts_o.blank_done) begin
      we    = 1'b1;
      waddr = cell_addr(sel_q, y_q, CB'(bc_q));
      wdat  = CH_SPACE;
    end else if (cmd_i.op == OP_PUT) begin
      we    = 1'b1;
      waddr = cell_addr(sel_q, y_q, CB'(x_q));
      wdat  = ch;
    end
  end

  always_comb begin
    ren   = pend_d;
    raddr = cell_addr(sel_q, RB'(sr_q), sc_q);
    if (cmd_i.op == OP_DECODE && in_q.action == ACT_CELL_READ && cell_ok) begin
      ren   = 1'b1;
      raddr = cell_addr(WB'(in_q.cell_window), RB'(in_q.cell_row), CB'(in_q.cell_col));
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdat;
    if (ren) rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CfgWin; i++) begin
        rows_q[i] <= ROWS_RESET[i];
        cols_q[i] <= COLS_RESET[i];
      end
      for (int i = 0; i < WINDOW_COUNT; i++) begin
        cur_x_q[i] <= '0;
        cur_y_q[i] <= '0;
      end
      sel_q       <= '0;
      key_q       <= '0;
      key_wait_q  <= 1'b0;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (cfg_valid_i) begin
        if (cfg_index_i[0]) cols_q[cfg_index_i[CfgIdxW-1:1]] <= cfg_data_i[ColsRegW-1:0];
        else rows_q[cfg_index_i[CfgIdxW-1:1]] <= cfg_data_i[RowsRegW-1:0];
      end
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + AW'(1);
      if (cmd_i.op == OP_COMMIT) begin
        cur_x_q[sel_q] <= x_q;
        cur_y_q[sel_q] <= y_q;
      end
      if (cmd_i.op == OP_DECODE) begin
        unique case (action_e'(in_q.action))
          ACT_PORT_READ: begin
            if (in_q.port == PORT_KEY) key_wait_q <= 1'b0;
          end
          ACT_PORT_WRITE: begin
            if (in_q.port == PORT_SELECT && int'(in_q.write_data) < WINDOW_COUNT) begin
              sel_q <= WB'(in_q.write_data);
            end
          end
          ACT_KEY_TYPED: begin
            key_wait_q <= 1'b1;
            if (in_q.key_code == 9'(BACKSPACE_KEY) || in_q.key_code == KEY_DEL) begin
              key_q <= KEY_BS;
            end else begin
              key_q <= in_q.key_code;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.op == OP_OUT) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pend_d) pend_addr_q <= cell_addr(sel_q, RB'(sr_q - RCW'(1)), sc_q);
    unique case (cmd_i.op)
      OP_LOAD: in_q <= in_data_i;
      OP_DECODE: begin
        rdata_q   <= '0;
        bad_q     <= 1'b0;
        cell_ok_q <= 1'b0;
        unique case (action_e'(in_q.action))
          ACT_PORT_READ: begin
            if (in_q.port == PORT_SELECT) rdata_q <= 16'(sel_q);
            else if (in_q.port == PORT_KEY) rdata_q <= 16'(key_q);
            else bad_q <= 1'b1;
          end
          ACT_PORT_WRITE: begin
            if (in_q.port == PORT_SELECT) begin
              if (int'(in_q.write_data) >= WINDOW_COUNT) bad_q <= 1'b1;
            end else if (in_q.port != PORT_UPLOAD) begin
              bad_q <= 1'b1;
            end
          end
          ACT_KEY_TYPED: ;
          default: begin
            if (cell_ok) cell_ok_q <= 1'b1;
            else bad_q <= 1'b1;
          end
        endcase
      end
      OP_PREP: begin
        x_q <= (cur_x_q[sel_q] > cols_eff) ? cols_eff : cur_x_q[sel_q];
        y_q <= (RCW'(cur_y_q[sel_q]) >= rows_eff) ? RB'(rows_eff - RCW'(1))
                                                   : cur_y_q[sel_q];
      end
      OP_DOWN: begin
        x_q  <= '0;
        if (!sts_o.last_row) y_q <= y_q + RB'(1);
        sr_q <= RCW'(1);
        sc_q <= '0;
      end
      OP_PUT: x_q <= x_q + CCW'(1);
      OP_NL: begin
        bc_q <= x_q;
        x_q  <= '0;
      end
      OP_CR: begin
        bc_q <= '0;
        x_q  <= '0;
      end
      OP_BLANK: begin
        if (!sts_o.blank_done) bc_q <= bc_q + CCW'(1);
      end
      OP_SCROLL: begin
        if (sts_o.scroll_done) begin
          bc_q <= '0;
        end else if ((CCW'(sc_q) + CCW'(1)) >= cols_eff) begin
          sc_q <= '0;
          sr_q <= sr_q + RCW'(1);
        end else begin
          sc_q <= sc_q + CB'(1);
        end
      end
      OP_OUT: begin
        out_q.read_data   <= rdata_q;
        out_q.cell_char   <= cell_ok_q ? rd_q : 8'd0;
        out_q.key_pending <= key_wait_q;
        out_q.bad_access  <= bad_q;
      end
      default: ;
    endcase
  end

  property p_copy_follows_read;
    @(posedge clk_i) disable iff (!rst_ni)
      pend_q |-> ($past(cmd_i.op) == OP_SCROLL);
  endproperty
  a_copy_follows_read: assert property (p_copy_follows_read)
    else $error("Scroll copy written without a preceding read.");

  property p_put_inside_row;
    @(posedge clk_i) disable iff (!rst_ni)
      (cmd_i.op == OP_PUT) |-> (x_q < cols_eff);
  endproperty
  a_put_inside_row: assert property (p_put_inside_row)
    else $error("Character stored beyond the columns in use.");

  property p_blank_inside_window;
    @(posedge clk_i) disable iff (!rst_ni)
      (cmd_i.op == OP_BLANK) |-> (RCW'(y_q) < rows_eff);
  endproperty
  a_blank_inside_window: assert property (p_blank_inside_window)
    else $error("Row blanked outside the rows in use.");

endmodule

// ===== hdl/multi_window_text_console.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-window text console
// Text windows with cursors, scrolling and a keyboard latch on a bus port.
// ----------------------------------------------------------------------------
// After reset the block writes spaces into all 2**(window bits + row bits +
// column bits) cells of the character memory (8192 with the defaults), one
// cell per cycle, and stalls its input meanwhile. It then takes one
// transaction at a time and stalls its input until that one has finished.
// A newline blanks the rest of the cursor's row and a carriage return the
// whole row; a newline or a wrap on the last row scrolls the window. The
// character memory, with one read port and one write port, moves and blanks
// one cell per cycle. Results wait in an output register, so a new
// transaction is taken while one is pending there.
module multi_window_text_console
  import mwtc_pkg::*;
#(
  parameter int MAX_ROWS      = 32,
  parameter int MAX_COLS      = 64,
  parameter int WINDOW_COUNT  = 4,
  parameter int BACKSPACE_KEY = 263
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  mwtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mwtc_datapath #(
    .MAX_ROWS      (MAX_ROWS),
    .MAX_COLS      (MAX_COLS),
    .WINDOW_COUNT  (WINDOW_COUNT),
    .BACKSPACE_KEY (BACKSPACE_KEY)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-window text console testbench
// Drives port accesses, key events, uploads and cell reads into the console,
// predicts every result with an internal model of the windows, the cursors
// and the keyboard latch, and compares each transaction field by field.
// ----------------------------------------------------------------------------
class console_scoreboard;
  logic [7:0] cells [4][32][64];
  int unsigned cur_col [4];
  int unsigned cur_row [4];
  int unsigned win_rows [4];
  int unsigned win_cols [4];
  logic [15:0] sel_win;
  logic [8:0] key_latch;
  logic key_flag;
  mwtc_pkg::out_t expected_results [$];
  int errors;
  int checked;

  function new();
    for (int w = 0; w < 4; w++) begin
      for (int r = 0; r < 32; r++) begin
        for (int c = 0; c < 64; c++) begin
          cells[w][r][c] = mwtc_pkg::CH_SPACE;
        end
      end
      cur_col[w] = 0;
      cur_row[w] = 0;
      win_rows[w] = mwtc_pkg::ROWS_RESET[w];
      win_cols[w] = mwtc_pkg::COLS_RESET[w];
    end
    sel_win = 0;
    key_latch = 0;
    key_flag = 0;
    errors = 0;
    checked = 0;
  endfunction

  function void write_reg(int unsigned idx, int unsigned value);
    if (idx % 2 == 0) win_rows[idx / 2] = value & 6'h3f;
    else win_cols[idx / 2] = value & 7'h7f;
  endfunction

  function int unsigned clamp(int unsigned v, int unsigned maxv);
    if (v < 1) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function void line_down(int unsigned w, ref int unsigned y, input int unsigned rows,
                          input int unsigned cols);
    y++;
    if (y >= rows) begin
      for (int r = 1; r < rows; r++) begin
        for (int c = 0; c < cols; c++) cells[w][r-1][c] = cells[w][r][c];
      end
      for (int c = 0; c < cols; c++) cells[w][rows-1][c] = mwtc_pkg::CH_SPACE;
      y = rows - 1;
    end
  endfunction

  function void print_char(int unsigned w, logic [7:0] ch);
    int unsigned rows;
    int unsigned cols;
    int unsigned x;
    int unsigned y;
    rows = clamp(win_rows[w], 32);
    cols = clamp(win_cols[w], 64);
    x = cur_col[w];
    y = cur_row[w];
    if (y >= rows) y = rows - 1;
    if (x > cols) x = cols;
    if (x >= cols) begin
      x = 0;
      line_down(w, y, rows, cols);
    end
    if (ch == mwtc_pkg::CH_NL) begin
      for (int c = x; c < cols; c++) cells[w][y][c] = mwtc_pkg::CH_SPACE;
      x = 0;
      line_down(w, y, rows, cols);
    end else if (ch == mwtc_pkg::CH_CR) begin
      x = 0;
      for (int c = 0; c < cols; c++) cells[w][y][c] = mwtc_pkg::CH_SPACE;
    end else begin
      cells[w][y][x] = ch;
      x++;
    end
    cur_col[w] = x;
    cur_row[w] = y;
  endfunction

  function void note_input(mwtc_pkg::in_t t);
    mwtc_pkg::out_t r;
    r = '0;
    case (t.action)
      mwtc_pkg::ACT_PORT_READ: begin
        if (t.port == mwtc_pkg::PORT_SELECT) r.read_data = sel_win;
        else if (t.port == mwtc_pkg::PORT_KEY) begin
          key_flag = 0;
          r.read_data = {7'd0, key_latch};
        end else r.bad_access = 1;
      end
      mwtc_pkg::ACT_PORT_WRITE: begin
        if (t.port == mwtc_pkg::PORT_SELECT) begin
          if (t.write_data < 4) sel_win = t.write_data;
          else r.bad_access = 1;
        end else if (t.port == mwtc_pkg::PORT_UPLOAD) print_char(sel_win, t.write_data[7:0]);
        else r.bad_access = 1;
      end
      mwtc_pkg::ACT_KEY_TYPED: begin
        if (t.key_code == 9'd263 || t.key_code == mwtc_pkg::KEY_DEL)
          key_latch = mwtc_pkg::KEY_BS;
        else key_latch = t.key_code;
        key_flag = 1;
      end
      default: begin
        r.cell_char = cells[t.cell_window][t.cell_row][t.cell_col];
      end
    endcase
    r.key_pending = key_flag;
    expected_results.push_back(r);
  endfunction

  function void check_result(mwtc_pkg::out_t got);
    mwtc_pkg::out_t e;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    e = expected_results.pop_front();
    checked++;
    if (got.read_data !== e.read_data) begin
      $display("%0t: read_data expected %h actual %h", $time, e.read_data, got.read_data);
      errors++;
    end
    if (got.cell_char !== e.cell_char) begin
      $display("%0t: cell_char expected %h actual %h", $time, e.cell_char, got.cell_char);
      errors++;
    end
    if (got.key_pending !== e.key_pending) begin
      $display("%0t: key_pending expected %b actual %b", $time, e.key_pending,
               got.key_pending);
      errors++;
    end
    if (got.bad_access !== e.bad_access) begin
      $display("%0t: bad_access expected %b actual %b", $time, e.bad_access, got.bad_access);
      errors++;
    end
  endfunction
endclass

module testbench;
  import mwtc_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  console_scoreboard console_model;
  bit calm;
  int quiet_cycles;
  int items_sent;

  multi_window_text_console dut (.*);

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    console_model = new();
    rst_ni = 0;
    in_valid_i = 0;
    in_data_i = '0;
    out_stall_i = 0;
    cfg_valid_i = 0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    calm = 0;
    quiet_cycles = 0;
    items_sent = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) console_model.check_result(out_data_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)
          || (cfg_valid_i && cfg_ready_o)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 40000) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Receiver stalls come in random bursts.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (calm || $urandom_range(0, 2) != 0) begin
        out_stall_i <= 0;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
    end
  end

  task automatic send_item(in_t t);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    console_model.note_input(t);
    items_sent++;
  endtask

  task automatic end_item();
    in_valid_i <= 0;
  endtask

  task automatic drain();
    end_item();
    @(posedge clk_i);
    while (console_model.expected_results.size() != 0) @(posedge clk_i);
    repeat (2200) @(posedge clk_i);
  endtask

  task automatic write_cfg(int unsigned idx, int unsigned value);
    cfg_valid_i <= 1;
    cfg_index_i <= idx[CfgIdxW-1:0];
    cfg_data_i <= value[CfgDataW-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    console_model.write_reg(idx, value[CfgDataW-1:0]);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic in_t make_item(action_e a, port_e p, int unsigned wd);
    in_t t;
    t = '0;
    t.action = a;
    t.port = p;
    t.write_data = wd[15:0];
    t.key_code = 9'($urandom);
    t.cell_window = 2'($urandom);
    t.cell_row = 5'($urandom);
    t.cell_col = 6'($urandom);
    return t;
  endfunction

  function automatic in_t random_item();
    in_t t;
    int unsigned pick;
    int unsigned ch;
    pick = $urandom_range(0, 99);
    ch = $urandom_range(32, 126);
    if ($urandom_range(0, 9) == 0) ch = CH_NL;
    else if ($urandom_range(0, 19) == 0) ch = CH_CR;
    else if ($urandom_range(0, 29) == 0) ch = $urandom_range(0, 255);
    if (pick < 45) t = make_item(ACT_PORT_WRITE, PORT_UPLOAD,
                                 {16'd0, 8'($urandom_range(0, 255)), 8'(ch)});
    else if (pick < 52) t = make_item(ACT_PORT_WRITE, PORT_SELECT,
                                       $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 3));
    else if (pick < 80) begin
      t = make_item(ACT_CELL_READ, port_e'(2'($urandom)), $urandom);
      t.cell_row = 5'($urandom_range(0, 11));
      t.cell_col = 6'($urandom_range(0, 25));
      if ($urandom_range(0, 3) == 0) begin
        t.cell_row = 5'($urandom);
        t.cell_col = 6'($urandom);
      end
    end else if (pick < 88) t = make_item(ACT_KEY_TYPED, port_e'(2'($urandom)), $urandom);
    else if (pick < 96) t = make_item(ACT_PORT_READ, port_e'(2'($urandom)), $urandom);
    else t = make_item(ACT_PORT_WRITE, port_e'(2'($urandom)), $urandom);
    return t;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_item(random_item());
  endtask

  initial begin
    in_t t;
    @(posedge rst_ni);
    @(posedge clk_i);
    // Directed part, with small windows so that wrap and scroll are reached.
    write_cfg(0, 2);
    write_cfg(1, 3);
    send_item(make_item(ACT_PORT_WRITE, PORT_UPLOAD, 16'hff41));
    send_item(make_item(ACT_PORT_WRITE, PORT_UPLOAD, 16'h0042));
    send_item(make_item(ACT_PORT_WRITE, PORT_UPLOAD, 16'h0043));
    send_item(make_item(ACT_PORT_WRITE, PORT_UPLOAD, 16'h0044));
    send_item(make_item(ACT_PORT_WRITE, PORT_UPLOAD, CH_NL));
    send_item(make_item(ACT_PORT_WRITE, PORT_UPLOAD, 16'h00fe));
    send_item(make_item(ACT_PORT_WRITE, PORT_UPLOAD, CH_CR));
    send_item(make_item(ACT_PORT_WRITE, PORT_UPLOAD, CH_NL));
    t = make_item(ACT_CELL_READ, PORT_SELECT, 0);
    t.cell_window = 0; t.cell_row = 0; t.cell_col = 0;
    send_item(t);
    t.cell_window = 3; t.cell_row = 31; t.cell_col = 63;
    send_item(t);
    send_item(make_item(ACT_PORT_WRITE, PORT_SELECT, 3));
    send_item(make_item(ACT_PORT_WRITE, PORT_SELECT, 16'hffff));
    send_item(make_item(ACT_PORT_WRITE, PORT_SELECT, 4));
    send_item(make_item(ACT_PORT_READ, PORT_SELECT, 0));
    send_item(make_item(ACT_PORT_READ, PORT_UPLOAD, 0));
    send_item(make_item(ACT_PORT_READ, PORT_INVALID, 0));
    send_item(make_item(ACT_PORT_WRITE, PORT_KEY, 16'hffff));
    send_item(make_item(ACT_PORT_WRITE, PORT_INVALID, 0));
    t = make_item(ACT_KEY_TYPED, PORT_SELECT, 0); t.key_code = 9'd263; send_item(t);
    send_item(make_item(ACT_PORT_READ, PORT_KEY, 0));
    t.key_code = KEY_DEL; send_item(t);
    t.key_code = 9'h1ff; send_item(t);
    send_item(make_item(ACT_PORT_READ, PORT_KEY, 0));
    t.key_code = 9'h000; send_item(t);
    send_item(make_item(ACT_PORT_WRITE, PORT_SELECT, 0));
    drain();
    // Shrink below the cursor, zero and oversized values, then extremes.
    for (int ph = 0; ph < 6; ph++) begin
      for (int i = 0; i < 8; i++) begin
        int unsigned v;
        case (ph)
          0: v = 0;
          1: v = 127;
          2: v = (i % 2 == 0) ? 32 : 64;
          3: v = 1;
          default: v = (i % 2 == 0) ? $urandom_range(1, 6) : $urandom_range(1, 12);
        endcase
        write_cfg(i, v);
      end
      random_phase(ph == 5 ? 200 : 100);
      drain();
    end
    calm = 1;
    random_phase(100);
    drain();
    $display("Ran %0d transactions through %0d checked results over several window sizes.",
             items_sent, console_model.checked);
    if (console_model.errors == 0 && console_model.expected_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/mwtc_pkg.sv
hdl/mwtc_ctrl.sv
hdl/mwtc_datapath.sv
hdl/multi_window_text_console.sv
tb/testbench.sv
